// File: sv/pid_controller_integral_clamp_macros.svh
// assertion macros for the pid controller top level
// expects clk and arst_n in the scope of use
`ifndef PID_CONTROLLER_INTEGRAL_CLAMP_MACROS_SVH
`define PID_CONTROLLER_INTEGRAL_CLAMP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PIDC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define PIDC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/pidc_pkg.sv
// shared types, constants and saturation helpers for the pid controller
// no dependencies; imported by every pidc module
package pidc_pkg;

	localparam int DATA_W    = 32;
	localparam int FRAC_W    = 16;
	localparam int DIGIT_W   = 4;
	localparam int NUM_REGS  = 7;
	localparam int PADDR_W   = $clog2(4 * NUM_REGS);
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	localparam longint ONE_Q    = longint'(1) << FRAC_W;
	localparam longint MAX_L    = (longint'(1) << (DATA_W - 1)) - 1;
	localparam longint LIM_FULL = 5000 * ONE_Q;

	localparam logic [DATA_W-2:0] TS_RST = (DATA_W-1)'(ONE_Q);
	localparam logic signed [DATA_W-1:0] LIM_HI_RST =
		DATA_W'((LIM_FULL > MAX_L) ? MAX_L : LIM_FULL);
	localparam logic signed [DATA_W-1:0] LIM_LO_RST =
		DATA_W'((-LIM_FULL < -MAX_L - 1) ? -MAX_L - 1 : -LIM_FULL);

	// smallest gain with gain*10000 >= one
	localparam logic signed [DATA_W-1:0] ACT_MIN = DATA_W'((ONE_Q + 9999) / 10000);

	typedef enum logic [1:0] {
		FUNC_MEASURE = 2'd0,
		FUNC_REUSE   = 2'd1,
		FUNC_LOAD    = 2'd2,
		FUNC_CLEAR   = 2'd3
	} func_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_SETPOINT  = REG_IDX_W'(0),
		REG_GAIN_P    = REG_IDX_W'(1),
		REG_GAIN_I    = REG_IDX_W'(2),
		REG_GAIN_D    = REG_IDX_W'(3),
		REG_TIME_STEP = REG_IDX_W'(4),
		REG_LIM_HI    = REG_IDX_W'(5),
		REG_LIM_LO    = REG_IDX_W'(6)
	} reg_idx_t;

	typedef struct packed {
		func_t                    func;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] drive;
		logic signed [DATA_W-1:0] p_term;
		logic signed [DATA_W-1:0] i_term;
		logic signed [DATA_W-1:0] d_term;
		logic                     active;
	} res_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] setpoint;
		logic signed [DATA_W-1:0] gain_p;
		logic signed [DATA_W-1:0] gain_i;
		logic signed [DATA_W-1:0] gain_d;
		logic        [DATA_W-2:0] time_step;
		logic signed [DATA_W-1:0] integ_limit_high;
		logic signed [DATA_W-1:0] integ_limit_low;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_INTEG,
		ST_CLAMP,
		ST_PMUL,
		ST_IMUL,
		ST_DWAIT,
		ST_DMUL,
		ST_SUM,
		ST_OUT
	} ctl_state_t;

	typedef enum logic [2:0] {
		DIV_IDLE,
		DIV_ABS,
		DIV_PREP,
		DIV_RUN,
		DIV_FIN
	} div_state_t;

	function automatic logic signed [DATA_W+1:0] ext2(input logic signed [DATA_W-1:0] x);
		return {{2{x[DATA_W-1]}}, x};
	endfunction

	// clip a two-bit-grown value back to the word range
	function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [DATA_W+1:0] x);
		logic [2:0] top;
		top = x[DATA_W+1:DATA_W-1];
		if (top == 3'b000 || top == 3'b111)
			return x[DATA_W-1:0];
		else if (x[DATA_W+1])
			return WORD_MIN;
		else
			return WORD_MAX;
	endfunction

	function automatic logic gain_active(input logic signed [DATA_W-1:0] g);
		return g >= ACT_MIN;
	endfunction

endpackage

// File: sv/pidc_mul.sv
// digit-serial signed multiplier, one DIGIT_W-bit digit of b per cycle
// product is floor-shifted by FRAC_W and saturated; depends on pidc_pkg
module pidc_mul import pidc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] a,
	input  logic signed [DATA_W-1:0] b,
	output logic                     busy,
	output logic signed [DATA_W-1:0] res
);

	localparam int DIGITS = (DATA_W + DIGIT_W - 1) / DIGIT_W;
	localparam int MB_W   = DIGITS * DIGIT_W;
	localparam int HI_W   = DATA_W + 1;
	localparam int SUM_W  = DATA_W + DIGIT_W + 1;
	localparam int P_W    = HI_W + MB_W;
	localparam int CNT_W  = $clog2(DIGITS + 1);

	logic signed [DATA_W-1:0] a_q;
	logic        [MB_W-1:0]   b_q;
	logic        [HI_W-1:0]   hi_q;
	logic        [MB_W-1:0]   lo_q;
	logic        [CNT_W-1:0]  cnt_q;
	logic                     fin_q;
	logic signed [DATA_W-1:0] res_q;

	logic signed [DIGIT_W:0]  dig;
	logic signed [SUM_W-1:0]  pp;
	logic        [SUM_W-1:0]  sum;
	logic signed [P_W-1:0]    prod;
	logic signed [P_W-1:0]    shr;
	logic [P_W-DATA_W:0]      top;
	logic signed [DATA_W-1:0] sat_res;

	// top digit carries the sign of b
	assign dig  = {(cnt_q == CNT_W'(1)) & b_q[DIGIT_W-1], b_q[DIGIT_W-1:0]};
	assign pp   = a_q * dig;
	assign sum  = {{DIGIT_W{hi_q[HI_W-1]}}, hi_q} + pp;
	assign prod = {hi_q, lo_q};
	assign shr  = prod >>> FRAC_W;
	assign top  = shr[P_W-1:DATA_W-1];

	always_comb begin
		if ((&top) || (~|top))
			sat_res = shr[DATA_W-1:0];
		else if (shr[P_W-1])
			sat_res = WORD_MIN;
		else
			sat_res = WORD_MAX;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIGITS);
			fin_q <= 1'b0;
		end else begin
			fin_q <= (cnt_q == CNT_W'(1));
			if (cnt_q != '0)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			b_q  <= MB_W'(b);
			hi_q <= '0;
		end else if (cnt_q != '0) begin
			hi_q <= sum[SUM_W-1:DIGIT_W];
			lo_q <= {sum[DIGIT_W-1:0], lo_q[MB_W-1:DIGIT_W]};
			b_q  <= b_q >> DIGIT_W;
		end
		if (fin_q)
			res_q <= sat_res;
	end

	assign busy = (cnt_q != '0) || fin_q;
	assign res  = res_q;

endmodule

// File: sv/pidc_div.sv
// bit-serial restoring divider for the derivative: (diff << FRAC_W) / time_step
// truncates toward zero and saturates; depends on pidc_pkg
module pidc_div import pidc_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] diff,
	input  logic        [DATA_W-2:0] ts,
	output logic                     busy,
	output logic signed [DATA_W-1:0] res
);

	localparam int Q_W   = DATA_W - 1;
	localparam int SH    = DATA_W - 1 - FRAC_W;
	localparam int CMP_W = DATA_W + SH;
	localparam int D_W   = DATA_W + FRAC_W;
	localparam int CNT_W = $clog2(DATA_W);

	div_state_t state_q, state_d;

	logic [CNT_W-1:0]         cnt_q;
	logic [DATA_W-1:0]        mag_q;
	logic                     neg_q;
	logic                     zero_q;
	logic [Q_W-1:0]           ts_q;
	logic [Q_W-1:0]           rem_q;
	logic [Q_W-1:0]           dq_q;
	logic signed [DATA_W-1:0] res_q;

	logic [D_W-1:0]    dvd;
	logic              big;
	logic [DATA_W-1:0] t;
	logic [DATA_W-1:0] tdiff;
	logic              ge;
	logic [DATA_W-1:0] q_ext;

	assign dvd   = D_W'(mag_q) << FRAC_W;
	// quotient would not fit the word
	assign big   = CMP_W'(mag_q) >= (CMP_W'(ts_q) << SH);
	assign t     = {rem_q, dq_q[Q_W-1]};
	assign ge    = t >= {1'b0, ts_q};
	assign tdiff = t - {1'b0, ts_q};
	assign q_ext = {1'b0, dq_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= DIV_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			DIV_IDLE: begin
				if (start)
					state_d = DIV_ABS;
			end
			DIV_ABS: state_d = DIV_PREP;
			DIV_PREP: begin
				if (zero_q || big)
					state_d = DIV_IDLE;
				else
					state_d = DIV_RUN;
			end
			DIV_RUN: begin
				if (cnt_q == CNT_W'(1))
					state_d = DIV_FIN;
			end
			DIV_FIN: state_d = DIV_IDLE;
			default: state_d = DIV_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= '0;
		else if (state_q == DIV_PREP)
			cnt_q <= CNT_W'(Q_W);
		else if (state_q == DIV_RUN)
			cnt_q <= cnt_q - CNT_W'(1);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			DIV_IDLE: begin
				if (start) begin
					mag_q <= diff;
					ts_q  <= ts;
				end
			end
			DIV_ABS: begin
				neg_q  <= mag_q[DATA_W-1];
				zero_q <= (mag_q == '0);
				mag_q  <= mag_q[DATA_W-1] ? (~mag_q + 1'b1) : mag_q;
			end
			DIV_PREP: begin
				if (zero_q)
					res_q <= '0;
				else if (big)
					res_q <= neg_q ? WORD_MIN : WORD_MAX;
				else begin
					rem_q <= Q_W'(dvd >> Q_W);
					dq_q  <= dvd[Q_W-1:0];
				end
			end
			DIV_RUN: begin
				rem_q <= ge ? tdiff[Q_W-1:0] : t[Q_W-1:0];
				dq_q  <= {dq_q[Q_W-2:0], ge};
			end
			DIV_FIN: res_q <= neg_q ? (~q_ext + 1'b1) : q_ext;
			default: ;
		endcase
	end

	assign busy = (state_q != DIV_IDLE);
	assign res  = res_q;

endmodule

// File: sv/pidc_regs.sv
// configuration register file behind an apb-style port
// resets to the controller defaults; depends on pidc_pkg
module pidc_regs import pidc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.setpoint         <= '0;
			cfg_q.gain_p           <= '0;
			cfg_q.gain_i           <= '0;
			cfg_q.gain_d           <= '0;
			cfg_q.time_step        <= TS_RST;
			cfg_q.integ_limit_high <= LIM_HI_RST;
			cfg_q.integ_limit_low  <= LIM_LO_RST;
		end else if (wr) begin
			case (idx)
				REG_SETPOINT:  cfg_q.setpoint         <= pwdata;
				REG_GAIN_P:    cfg_q.gain_p           <= pwdata;
				REG_GAIN_I:    cfg_q.gain_i           <= pwdata;
				REG_GAIN_D:    cfg_q.gain_d           <= pwdata;
				REG_TIME_STEP: cfg_q.time_step        <= pwdata[DATA_W-2:0];
				REG_LIM_HI:    cfg_q.integ_limit_high <= pwdata;
				REG_LIM_LO:    cfg_q.integ_limit_low  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_SETPOINT:  prdata = cfg_q.setpoint;
			REG_GAIN_P:    prdata = cfg_q.gain_p;
			REG_GAIN_I:    prdata = cfg_q.gain_i;
			REG_GAIN_D:    prdata = cfg_q.gain_d;
			REG_TIME_STEP: prdata = {1'b0, cfg_q.time_step};
			REG_LIM_HI:    prdata = cfg_q.integ_limit_high;
			REG_LIM_LO:    prdata = cfg_q.integ_limit_low;
			default:       prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// File: sv/pid_controller_integral_clamp.sv
// pid controller with integral clamp: sequencer, state and output register
// update transaction: the next command is taken the cycle after the result is registered;
// commands stall until then; the result waits while a valid result is still stalled
// bit-serial divide overlaps the integral, p and i multiplies; the d multiply follows it
// load and clear act on acceptance; async reset clears errors, integral, output
// valid and loads register defaults; depends on pidc_pkg, pidc_mul, pidc_div, pidc_regs
`include "pid_controller_integral_clamp_macros.svh"

module pid_controller_integral_clamp import pidc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  cmd_t               cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output res_t               res
);

	cfg_t       cfg;
	ctl_state_t state_q, state_d;

	logic signed [DATA_W-1:0] cur_err_q;
	logic signed [DATA_W-1:0] prev_err_q;
	logic signed [DATA_W-1:0] integ_q;
	logic signed [DATA_W-1:0] acc_q;
	logic signed [DATA_W+1:0] sum_q;
	logic signed [DATA_W-1:0] p_q;
	logic signed [DATA_W-1:0] i_q;
	logic signed [DATA_W-1:0] d_q;
	res_t                     res_q;
	logic                     res_valid_q;

	logic                     cmd_acc;
	logic                     out_go;
	logic                     mul_start;
	logic signed [DATA_W-1:0] mul_a;
	logic signed [DATA_W-1:0] mul_b;
	logic                     mul_busy;
	logic signed [DATA_W-1:0] mul_res;
	logic                     div_start;
	logic signed [DATA_W-1:0] div_diff;
	logic                     div_busy;
	logic signed [DATA_W-1:0] div_res;
	logic signed [DATA_W-1:0] lim_hi;
	logic signed [DATA_W-1:0] lim_lo;
	logic signed [DATA_W-1:0] clamp_val;
	logic                     act;

	pidc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pidc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.res    (mul_res)
	);

	pidc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.diff   (div_diff),
		.ts     (cfg.time_step),
		.busy   (div_busy),
		.res    (div_res)
	);

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign out_go    = (state_q == ST_OUT) && (!res_valid_q || !res_stall);

	assign div_diff  = sat_word(ext2(cur_err_q) - ext2(prev_err_q));
	assign lim_hi    = cfg.integ_limit_high;
	assign lim_lo    = cfg.integ_limit_low;
	// high limit tested first; crossed limits give high above it, low for all other values
	assign clamp_val = (acc_q > lim_hi) ? lim_hi : ((acc_q < lim_lo) ? lim_lo : acc_q);
	assign act       = gain_active(cfg.gain_p) || gain_active(cfg.gain_i) ||
		gain_active(cfg.gain_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = cur_err_q;
		mul_b     = DATA_W'(cfg.time_step);
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_acc && (cmd.func == FUNC_MEASURE || cmd.func == FUNC_REUSE))
					state_d = ST_START;
			end
			ST_START: begin
				mul_start = 1'b1;
				div_start = 1'b1;
				state_d   = ST_INTEG;
			end
			ST_INTEG: begin
				if (!mul_busy)
					state_d = ST_CLAMP;
			end
			ST_CLAMP: begin
				mul_start = 1'b1;
				mul_a     = cfg.gain_p;
				mul_b     = cur_err_q;
				state_d   = ST_PMUL;
			end
			ST_PMUL: begin
				mul_a = cfg.gain_i;
				mul_b = integ_q;
				if (!mul_busy) begin
					mul_start = 1'b1;
					state_d   = ST_IMUL;
				end
			end
			ST_IMUL: begin
				if (!mul_busy)
					state_d = ST_DWAIT;
			end
			ST_DWAIT: begin
				mul_a = cfg.gain_d;
				mul_b = div_res;
				if (!div_busy) begin
					mul_start = 1'b1;
					state_d   = ST_DMUL;
				end
			end
			ST_DMUL: begin
				if (!mul_busy)
					state_d = ST_SUM;
			end
			ST_SUM: state_d = ST_OUT;
			ST_OUT: begin
				if (out_go)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// controller state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_err_q   <= '0;
			prev_err_q  <= '0;
			integ_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd_acc) begin
				case (cmd.func)
					FUNC_MEASURE: cur_err_q <= sat_word(ext2(cfg.setpoint) - ext2(cmd.value));
					FUNC_LOAD:    cur_err_q <= cmd.value;
					FUNC_CLEAR: begin
						cur_err_q  <= '0;
						prev_err_q <= '0;
						integ_q    <= '0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_CLAMP) begin
				integ_q    <= clamp_val;
				prev_err_q <= cur_err_q;
			end
			if (out_go)
				res_valid_q <= 1'b1;
			else if (!res_stall)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INTEG && !mul_busy)
			acc_q <= sat_word(ext2(integ_q) + ext2(mul_res));
		if (state_q == ST_PMUL && !mul_busy)
			p_q <= mul_res;
		if (state_q == ST_IMUL && !mul_busy)
			i_q <= mul_res;
		if (state_q == ST_DMUL && !mul_busy)
			d_q <= mul_res;
		if (state_q == ST_SUM)
			sum_q <= ext2(p_q) + ext2(i_q);
		if (out_go) begin
			res_q.drive  <= sat_word(sum_q + ext2(d_q));
			res_q.p_term <= p_q;
			res_q.i_term <= i_q;
			res_q.d_term <= d_q;
			res_q.active <= act;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	`PIDC_ASSERT_NEXT(a_integ_in_limits, state_q == ST_CLAMP && lim_lo <= lim_hi, integ_q <= $past(lim_hi) && integ_q >= $past(lim_lo), "integral outside clamp limits")
	`PIDC_ASSERT_SAME(a_units_idle_at_out, state_q == ST_OUT, !mul_busy && !div_busy, "arithmetic unit still busy when result is formed")
	`PIDC_ASSERT_NEXT(a_clear_state, cmd_acc && cmd.func == FUNC_CLEAR, cur_err_q == '0 && prev_err_q == '0 && integ_q == '0, "clear transaction left controller state")

endmodule

// File: dv/testbench.sv
// self-checking testbench for the pid controller with integral clamp
// holds a scoreboard with its own fixed-point pid predictor; needs pidc_pkg and the rtl
// drives commands and register writes, randomizes stalls and gaps, checks every result
module testbench import pidc_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ONE             = 65536;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int SETTLE_CYCLES   = 60;
	localparam int SINK_HOLD       = 400;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               cmd_valid;
	logic               cmd_stall;
	cmd_t               cmd;
	logic               res_valid;
	logic               res_stall;
	res_t               res;

	logic               quiet = 1'b0;
	logic               sink_hold_req = 1'b0;
	logic [DATA_W-1:0]  cfg_v [NUM_REGS];
	int                 settings_used = 0;

	pid_controller_integral_clamp dut (.*);

	always #5 clk = ~clk;

	class pid_scoreboard;
		longint setpoint, gain_p, gain_i, gain_d, time_step, lim_hi, lim_lo;
		longint cur_err, prev_err, integ_acc;
		res_t   expected_q[$];
		int     mismatches;
		int     cmds_seen;
		int     results_checked;

		function void reset_state();
			setpoint  = 0;
			gain_p    = 0;
			gain_i    = 0;
			gain_d    = 0;
			time_step = ONE_Q;
			lim_hi    = 5000 * ONE_Q;
			lim_lo    = -5000 * ONE_Q;
			cur_err   = 0;
			prev_err  = 0;
			integ_acc = 0;
			mismatches      = 0;
			cmds_seen       = 0;
			results_checked = 0;
		endfunction

		function longint sat32(longint x);
			if (x > MAX_L)
				return MAX_L;
			if (x < -MAX_L - 1)
				return -MAX_L - 1;
			return x;
		endfunction

		// exact product, floor shift, saturate
		function longint qmul(longint a, longint b);
			return sat32((a * b) >>> FRAC_W);
		endfunction

		function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] v);
			case (idx)
				REG_SETPOINT:  setpoint  = longint'(signed'(v));
				REG_GAIN_P:    gain_p    = longint'(signed'(v));
				REG_GAIN_I:    gain_i    = longint'(signed'(v));
				REG_GAIN_D:    gain_d    = longint'(signed'(v));
				REG_TIME_STEP: time_step = longint'(v[DATA_W-2:0]);
				REG_LIM_HI:    lim_hi    = longint'(signed'(v));
				REG_LIM_LO:    lim_lo    = longint'(signed'(v));
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_cmd(cmd_t c);
			longint val, integ, diff, deriv, p, i, d, drive;
			res_t   e;
			val = c.value;
			cmds_seen++;
			case (c.func)
				FUNC_LOAD: begin
					cur_err = val;
					return;
				end
				FUNC_CLEAR: begin
					cur_err   = 0;
					prev_err  = 0;
					integ_acc = 0;
					return;
				end
				FUNC_MEASURE: cur_err = sat32(setpoint - val);
				default: ;
			endcase
			integ = sat32(integ_acc + qmul(cur_err, time_step));
			// high limit tested first; crossed limits give high above it, low for all other values
			if (integ > lim_hi)
				integ = lim_hi;
			else if (integ < lim_lo)
				integ = lim_lo;
			integ_acc = integ;
			diff = sat32(cur_err - prev_err);
			if (time_step == 0)
				deriv = (diff > 0) ? MAX_L : ((diff < 0) ? -MAX_L - 1 : 0);
			else
				deriv = sat32((diff * ONE_Q) / time_step);
			p = qmul(gain_p, cur_err);
			i = qmul(gain_i, integ);
			d = qmul(gain_d, deriv);
			drive = sat32(p + i + d);
			prev_err = cur_err;
			e.drive  = drive[DATA_W-1:0];
			e.p_term = p[DATA_W-1:0];
			e.i_term = i[DATA_W-1:0];
			e.d_term = d[DATA_W-1:0];
			e.active = (gain_p * 10000 >= ONE_Q) || (gain_i * 10000 >= ONE_Q) ||
				(gain_d * 10000 >= ONE_Q);
			expected_q.push_back(e);
		endfunction

		task flag_mismatch(string what);
			mismatches++;
			$display("[%0t] %s", $time, what);
		endtask

		task check_res(res_t r);
			res_t e;
			if (expected_q.size() == 0) begin
				flag_mismatch("result with no command waiting for it");
				return;
			end
			e = expected_q.pop_front();
			results_checked++;
			if (r.drive !== e.drive)
				flag_mismatch($sformatf("drive got %0d expected %0d", r.drive, e.drive));
			if (r.p_term !== e.p_term)
				flag_mismatch($sformatf("p_term got %0d expected %0d", r.p_term, e.p_term));
			if (r.i_term !== e.i_term)
				flag_mismatch($sformatf("i_term got %0d expected %0d", r.i_term, e.i_term));
			if (r.d_term !== e.d_term)
				flag_mismatch($sformatf("d_term got %0d expected %0d", r.d_term, e.d_term));
			if (r.active !== e.active)
				flag_mismatch($sformatf("active got %b expected %b", r.active, e.active));
		endtask

		task drain_leftovers();
			while (expected_q.size() != 0) begin
				void'(expected_q.pop_front());
				flag_mismatch("expected result never arrived");
			end
		endtask
	endclass

	pid_scoreboard sb = new;

	// accepted transactions on both channels
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall)
			sb.note_cmd(cmd);
		if (arst_n && res_valid && !res_stall)
			sb.check_res(res);
	end

	// result side: random stalls, or one long hold-off on request
	initial begin
		forever begin
			if (sink_hold_req) begin
				res_stall <= 1'b1;
				repeat (SINK_HOLD) @(posedge clk);
				sink_hold_req = 1'b0;
			end else begin
				res_stall <= !quiet && ($urandom_range(99) < 8);
				@(posedge clk);
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] rand_word();
		case ($urandom_range(9))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2, 3, 4: return $urandom;
			default: return int'($urandom_range(0, 2 << 20)) - (1 << 20);
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_gain();
		case ($urandom_range(7))
			0: return WORD_MAX;
			1: return WORD_MIN;
			2: return $urandom_range(0, 7);
			3: return $urandom;
			default: return int'($urandom_range(0, 8 * ONE)) - 4 * ONE;
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] rand_step();
		case ($urandom_range(7))
			0: return 32'h7fff_ffff;
			1: return 1;
			2: return $urandom;
			default: return $urandom_range(1, 4 * ONE);
		endcase
	endfunction

	task automatic rand_settings();
		logic signed [DATA_W-1:0] a;
		cfg_v[REG_SETPOINT]  = rand_word();
		cfg_v[REG_GAIN_P]    = rand_gain();
		cfg_v[REG_GAIN_I]    = rand_gain();
		cfg_v[REG_GAIN_D]    = rand_gain();
		cfg_v[REG_TIME_STEP] = rand_step();
		case ($urandom_range(5))
			0: begin
				cfg_v[REG_LIM_HI] = WORD_MAX;
				cfg_v[REG_LIM_LO] = WORD_MIN;
			end
			1: begin
				cfg_v[REG_LIM_HI] = $urandom;
				cfg_v[REG_LIM_LO] = $urandom;
			end
			default: begin
				a = $urandom_range(1, 2000 * ONE);
				cfg_v[REG_LIM_HI] = a;
				cfg_v[REG_LIM_LO] = -int'($urandom_range(1, 2000 * ONE));
			end
		endcase
	endtask

	task automatic apb_write(reg_idx_t idx, logic [DATA_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		sb.set_reg(idx, v);
		@(posedge clk);
	endtask

	task automatic program_regs();
		for (int k = 0; k < NUM_REGS; k++)
			apb_write(reg_idx_t'(k), cfg_v[k]);
		settings_used++;
	endtask

	task automatic send_cmd(func_t f, logic signed [DATA_W-1:0] v);
		cmd_t c;
		c.func  = f;
		c.value = v;
		if (!quiet && $urandom_range(99) < 8) begin
			cmd_valid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
	endtask

	// sender pause: nothing in flight, then a settling margin
	task automatic wait_drain();
		cmd_valid <= 1'b0;
		// let the monitor log the last accepted command first
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic rand_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			send_cmd(FUNC_MEASURE, rand_word());
		else if (r < 72)
			send_cmd(FUNC_REUSE, rand_word());
		else if (r < 95)
			send_cmd(FUNC_LOAD, rand_word());
		else
			send_cmd(FUNC_CLEAR, rand_word());
	endtask

	initial begin
		int ph, k, n;
		sb.reset_state();
		arst_n    <= 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset values: zero gains, unit step, default clamp
		send_cmd(FUNC_MEASURE, 0);
		send_cmd(FUNC_MEASURE, WORD_MIN);
		send_cmd(FUNC_REUSE, 0);
		wait_drain();

		cfg_v[REG_SETPOINT]  = ONE;
		cfg_v[REG_GAIN_P]    = ONE;
		cfg_v[REG_GAIN_I]    = ONE / 2;
		cfg_v[REG_GAIN_D]    = ONE / 4;
		cfg_v[REG_TIME_STEP] = ONE;
		cfg_v[REG_LIM_HI]    = 100 * ONE;
		cfg_v[REG_LIM_LO]    = -100 * ONE;
		program_regs();
		send_cmd(FUNC_CLEAR, 0);
		send_cmd(FUNC_LOAD, WORD_MAX);
		send_cmd(FUNC_REUSE, 0);
		send_cmd(FUNC_LOAD, WORD_MIN);
		send_cmd(FUNC_REUSE, 0);
		send_cmd(FUNC_MEASURE, WORD_MAX);
		send_cmd(FUNC_MEASURE, WORD_MIN);
		send_cmd(FUNC_MEASURE, 0);
		send_cmd(FUNC_MEASURE, -1);
		send_cmd(FUNC_LOAD, 0);
		send_cmd(FUNC_CLEAR, WORD_MAX);
		send_cmd(FUNC_REUSE, 0);
		wait_drain();

		// zero step, crossed limits, extreme gains, gain just at the activity threshold
		cfg_v[REG_SETPOINT]  = WORD_MIN;
		cfg_v[REG_GAIN_P]    = WORD_MAX;
		cfg_v[REG_GAIN_I]    = WORD_MIN;
		cfg_v[REG_GAIN_D]    = 7;
		cfg_v[REG_TIME_STEP] = 0;
		cfg_v[REG_LIM_HI]    = -100 * ONE;
		cfg_v[REG_LIM_LO]    = 100 * ONE;
		program_regs();
		send_cmd(FUNC_MEASURE, 1);
		send_cmd(FUNC_MEASURE, WORD_MAX);
		send_cmd(FUNC_REUSE, 0);
		send_cmd(FUNC_LOAD, -5 * ONE);
		send_cmd(FUNC_REUSE, 0);
		wait_drain();

		// all gains below threshold, negative one too; step with the unused top bit set
		cfg_v[REG_GAIN_P]    = -1;
		cfg_v[REG_GAIN_I]    = 6;
		cfg_v[REG_GAIN_D]    = 6;
		cfg_v[REG_TIME_STEP] = 32'hffff_ffff;
		cfg_v[REG_LIM_HI]    = WORD_MAX;
		cfg_v[REG_LIM_LO]    = WORD_MIN;
		program_regs();
		send_cmd(FUNC_MEASURE, WORD_MAX);
		send_cmd(FUNC_REUSE, 0);
		send_cmd(FUNC_LOAD, 3 * ONE);
		send_cmd(FUNC_REUSE, 0);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drain();
			rand_settings();
			if (ph == 0) begin
				cfg_v[REG_GAIN_P]    = 2 * ONE;
				cfg_v[REG_GAIN_I]    = ONE / 8;
				cfg_v[REG_GAIN_D]    = ONE / 2;
				cfg_v[REG_TIME_STEP] = ONE / 100;
			end else if (ph == 1) begin
				cfg_v[REG_GAIN_P]    = WORD_MAX;
				cfg_v[REG_GAIN_I]    = WORD_MIN;
				cfg_v[REG_GAIN_D]    = WORD_MAX;
				cfg_v[REG_TIME_STEP] = 1;
				cfg_v[REG_LIM_HI]    = WORD_MAX;
				cfg_v[REG_LIM_LO]    = WORD_MIN;
			end else if (ph == 6) begin
				cfg_v[REG_TIME_STEP] = 32'h7fff_ffff;
				cfg_v[REG_LIM_HI]    = WORD_MIN;
				cfg_v[REG_LIM_LO]    = WORD_MAX;
			end
			program_regs();
			quiet = (ph == 2);
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				// result side holds off while commands keep coming
				if (ph == 3 && k == 20)
					sink_hold_req = 1'b1;
				if (ph == 5 && k == ITEMS_PER_PHASE / 2)
					wait_drain();
				rand_cmd();
			end
		end
		quiet = 1'b0;

		cmd_valid <= 1'b0;
		@(posedge clk);
		for (n = 0; n < 20000 && sb.pending() != 0; n++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.drain_leftovers();

		$display("covered %0d commands and %0d checked results over %0d register settings",
			sb.cmds_seen, sb.results_checked, settings_used);
		$display("included zero step, crossed clamp limits, saturating gains and errors");
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("timeout with %0d results outstanding", sb.pending());
		$display("Mismatches found");
		$finish;
	end

endmodule
